// ===== src/combined_lcg_shuffle_prng_assert.svh =====
// assertion macros for the combined lcg shuffle generator
// used by the top level, no other dependencies
`ifndef COMBINED_LCG_SHUFFLE_PRNG_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_PRNG_ASSERT_SVH

// same-cycle implication check
`define CLSP_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication check
`define CLSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/clsp_pkg.sv =====
// shared types and constants for the combined lcg shuffle generator
// no dependencies
package clsp_pkg;

	// generator constants
	localparam logic [15:0] MUL1 = 16'd40014;
	localparam logic [15:0] MUL2 = 16'd40692;
	localparam logic [30:0] MOD1 = 31'd2147483563;
	localparam logic [30:0] MOD2 = 31'd2147483399;
	localparam int WARMUP_EXTRA = 7;
	localparam int TABLE_SIZE_DEF = 32;

	// serial operand length and bit counter width
	localparam int BIT_W = 31;
	localparam int BIT_CW = 5;

	typedef logic [BIT_W-1:0] word_t;

	// request command codes
	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_SEED = 1'b1;

	// control of one serial unit
	typedef struct packed {
		logic load;
		logic step;
	} unit_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW_MUL,
		ST_DRAW_READ,
		ST_DRAW_DONE,
		ST_SEED_MUL,
		ST_SEED_STORE
	} state_t;

endpackage

// ===== src/clsp_modmul.sv =====
// bit-serial modular multiplier by a constant, one operand bit per cycle while step is high
// depends on clsp_pkg
module clsp_modmul #(
	parameter logic [15:0] MUL = clsp_pkg::MUL1,
	parameter logic [30:0] MOD = clsp_pkg::MOD1
) (
	input  logic                 clk,
	input  clsp_pkg::unit_ctl_t  ctl,
	input  clsp_pkg::word_t      x,
	output clsp_pkg::word_t      acc
);

	localparam logic [32:0] MOD_X1 = {2'b00, MOD};
	localparam logic [32:0] MOD_X2 = {1'b0, MOD, 1'b0};

	clsp_pkg::word_t opnd_q;
	clsp_pkg::word_t acc_q;
	logic [32:0] sum;
	logic [32:0] sub1;
	logic [32:0] sub2;
	clsp_pkg::word_t acc_next;

	// horner step: acc = 2*acc + bit*mul, brought back below the modulus
	always_comb begin
		sum  = {1'b0, acc_q, 1'b0} + (opnd_q[clsp_pkg::BIT_W-1] ? {17'd0, MUL} : 33'd0);
		sub1 = sum - MOD_X1;
		sub2 = sum - MOD_X2;
		priority if (sum >= MOD_X2) begin
			acc_next = sub2[30:0];
		end else if (sum >= MOD_X1) begin
			acc_next = sub1[30:0];
		end else begin
			acc_next = sum[30:0];
		end
	end

	// operand shifts out msb first
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			opnd_q <= x;
			acc_q  <= '0;
		end else if (ctl.step) begin
			opnd_q <= {opnd_q[clsp_pkg::BIT_W-2:0], 1'b0};
			acc_q  <= acc_next;
		end
	end

	assign acc = acc_q;

endmodule

// ===== src/clsp_slotdiv.sv =====
// bit-serial divider by a constant, gives the shuffle slot quotient
// depends on clsp_pkg
module clsp_slotdiv #(
	parameter logic [30:0] DIVISOR = 31'd67108862,
	parameter int          QW      = 6
) (
	input  logic                 clk,
	input  clsp_pkg::unit_ctl_t  ctl,
	input  clsp_pkg::word_t      dividend,
	output logic [QW-1:0]        quotient
);

	clsp_pkg::word_t opnd_q;
	clsp_pkg::word_t rem_q;
	logic [QW-1:0] quot_q;
	logic [31:0] trial;
	logic [31:0] diff;
	logic ge;
	logic [QW:0] quot_shift;

	// restoring step: bring down one dividend bit, subtract when it fits
	always_comb begin
		trial      = {rem_q, opnd_q[clsp_pkg::BIT_W-1]};
		ge         = (trial >= {1'b0, DIVISOR});
		diff       = trial - {1'b0, DIVISOR};
		quot_shift = {quot_q, ge};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			opnd_q <= dividend;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (ctl.step) begin
			opnd_q <= {opnd_q[clsp_pkg::BIT_W-2:0], 1'b0};
			rem_q  <= ge ? diff[30:0] : trial[30:0];
			quot_q <= quot_shift[QW-1:0];
		end
	end

	assign quotient = quot_q;

endmodule

// ===== src/clsp_table.sv =====
// shuffle table memory, registered read, per-entry valid bits for reset
// depends on clsp_pkg
module clsp_table #(
	parameter int DEPTH = clsp_pkg::TABLE_SIZE_DEF,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  clsp_pkg::word_t  wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output clsp_pkg::word_t  rdata
);

	clsp_pkg::word_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	clsp_pkg::word_t rdata_q;

	// entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// write port and registered read port, unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/combined_lcg_shuffle_prng.sv =====
// top level of the combined lcg generator with shuffle table
// depends on clsp_pkg, clsp_modmul, clsp_slotdiv, clsp_table and the assertion header
//
// Two multiplicative congruential generators (moduli 2147483563 and 2147483399) feed a
// shuffle table of TABLE_SIZE entries. A request with command 0 draws one number in
// 1..2147483562 (the uniform fraction is that value over 2147483563); a request with
// command 1 reseeds from seed_value (zero counts as one) and returns nothing. Both
// generator steps run in bit-serial multipliers that take one bit of the 31-bit state
// per cycle. A draw runs the multiply, a table read and the combine; a reseed runs
// WARMUP_EXTRA+1 warm-up rounds and then one per table entry, each a multiply and a
// store. req_stall is high while a request is in work; a finished result waits in the
// output register while the next request is already taken.
`include "combined_lcg_shuffle_prng_assert.svh"

module combined_lcg_shuffle_prng #(
	parameter int TABLE_SIZE = clsp_pkg::TABLE_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                command,
	input  clsp_pkg::word_t     seed_value,
	output logic                res_valid,
	input  logic                res_stall,
	output clsp_pkg::word_t     random_value
);

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int QW = $clog2(TABLE_SIZE + 1);
	localparam int JW = $clog2(TABLE_SIZE + clsp_pkg::WARMUP_EXTRA + 1);
	localparam logic [30:0] SLOT_DIV = 31'(1 + (clsp_pkg::MOD1 - 31'd1) / TABLE_SIZE);
	localparam logic [QW-1:0] SLOT_MAX = QW'(TABLE_SIZE - 1);
	localparam logic [JW-1:0] J_START = JW'(TABLE_SIZE + clsp_pkg::WARMUP_EXTRA);
	localparam logic [JW-1:0] J_TS = JW'(TABLE_SIZE);
	localparam logic [clsp_pkg::BIT_CW-1:0] BIT_LAST = clsp_pkg::BIT_CW'(clsp_pkg::BIT_W - 1);
	localparam logic [30:0] MOD1_M1 = clsp_pkg::MOD1 - 31'd1;

	clsp_pkg::state_t state_q;
	clsp_pkg::state_t state_next;
	logic [clsp_pkg::BIT_CW-1:0] bit_q;
	logic [JW-1:0] seed_j_q;
	clsp_pkg::word_t gen1_q;
	clsp_pkg::word_t gen2_q;
	clsp_pkg::word_t last_q;
	logic res_valid_q;
	clsp_pkg::word_t random_value_q;

	logic req_accept;
	logic out_free;
	logic bit_end;
	clsp_pkg::word_t seed_eff;
	clsp_pkg::unit_ctl_t mul1_ctl;
	clsp_pkg::unit_ctl_t draw_ctl;
	clsp_pkg::word_t mul1_x;
	clsp_pkg::word_t mul1_acc;
	clsp_pkg::word_t mul2_acc;
	logic [QW-1:0] quot;
	logic [AW-1:0] slot;
	logic tbl_we;
	logic tbl_re;
	logic [AW-1:0] tbl_waddr;
	clsp_pkg::word_t tbl_rdata;
	logic [31:0] diff;
	clsp_pkg::word_t y_fix;
	logic draw_req;
	logic res_in_range;

	assign req_accept = req_valid && !req_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign bit_end    = (bit_q == BIT_LAST);
	assign seed_eff   = (seed_value == '0) ? clsp_pkg::word_t'(1) : seed_value;

	// serial units
	clsp_modmul #(
		.MUL (clsp_pkg::MUL1),
		.MOD (clsp_pkg::MOD1)
	) u_mul1 (
		.clk (clk),
		.ctl (mul1_ctl),
		.x   (mul1_x),
		.acc (mul1_acc)
	);

	clsp_modmul #(
		.MUL (clsp_pkg::MUL2),
		.MOD (clsp_pkg::MOD2)
	) u_mul2 (
		.clk (clk),
		.ctl (draw_ctl),
		.x   (gen2_q),
		.acc (mul2_acc)
	);

	clsp_slotdiv #(
		.DIVISOR (SLOT_DIV),
		.QW      (QW)
	) u_div (
		.clk      (clk),
		.ctl      (draw_ctl),
		.dividend (last_q),
		.quotient (quot)
	);

	clsp_table #(
		.DEPTH (TABLE_SIZE),
		.AW    (AW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wdata  (mul1_acc),
		.re     (tbl_re),
		.raddr  (slot),
		.rdata  (tbl_rdata)
	);

	// slot index, saturated to the last entry
	assign slot = (quot > SLOT_MAX) ? AW'(TABLE_SIZE - 1) : quot[AW-1:0];

	// combine table entry with second generator, wrap non-positive values
	always_comb begin
		diff  = {1'b0, tbl_rdata} - {1'b0, mul2_acc};
		y_fix = (diff[31] || (diff == '0)) ? diff[30:0] + MOD1_M1 : diff[30:0];
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			clsp_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_next = (command == clsp_pkg::CMD_SEED) ? clsp_pkg::ST_SEED_MUL
					                                             : clsp_pkg::ST_DRAW_MUL;
				end
			end
			clsp_pkg::ST_DRAW_MUL: begin
				if (bit_end) begin
					state_next = clsp_pkg::ST_DRAW_READ;
				end
			end
			clsp_pkg::ST_DRAW_READ: begin
				state_next = clsp_pkg::ST_DRAW_DONE;
			end
			clsp_pkg::ST_DRAW_DONE: begin
				if (out_free) begin
					state_next = clsp_pkg::ST_IDLE;
				end
			end
			clsp_pkg::ST_SEED_MUL: begin
				if (bit_end) begin
					state_next = clsp_pkg::ST_SEED_STORE;
				end
			end
			clsp_pkg::ST_SEED_STORE: begin
				state_next = (seed_j_q == '0) ? clsp_pkg::ST_IDLE : clsp_pkg::ST_SEED_MUL;
			end
			default: begin
				state_next = clsp_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall     = 1'b1;
		mul1_ctl      = '0;
		draw_ctl      = '0;
		mul1_x        = mul1_acc;
		tbl_we        = 1'b0;
		tbl_re        = 1'b0;
		tbl_waddr     = slot;
		unique case (state_q)
			clsp_pkg::ST_IDLE: begin
				req_stall     = 1'b0;
				mul1_ctl.load = req_valid;
				draw_ctl.load = req_valid;
				mul1_x        = (command == clsp_pkg::CMD_SEED) ? seed_eff : gen1_q;
			end
			clsp_pkg::ST_DRAW_MUL: begin
				mul1_ctl.step = 1'b1;
				draw_ctl.step = 1'b1;
			end
			clsp_pkg::ST_DRAW_READ: begin
				tbl_re = 1'b1;
			end
			clsp_pkg::ST_DRAW_DONE: begin
				tbl_we = out_free;
			end
			clsp_pkg::ST_SEED_MUL: begin
				mul1_ctl.step = 1'b1;
			end
			clsp_pkg::ST_SEED_STORE: begin
				tbl_we        = (seed_j_q < J_TS);
				tbl_waddr     = seed_j_q[AW-1:0];
				mul1_ctl.load = (seed_j_q != '0);
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// control and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clsp_pkg::ST_IDLE;
			bit_q       <= '0;
			seed_j_q    <= '0;
			gen1_q      <= '0;
			gen2_q      <= '0;
			last_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;

			// bit counter of the serial units
			if ((state_q == clsp_pkg::ST_DRAW_MUL) || (state_q == clsp_pkg::ST_SEED_MUL)) begin
				bit_q <= bit_end ? '0 : bit_q + 1'b1;
			end else begin
				bit_q <= '0;
			end

			// seed load and warm-up countdown
			if (req_accept && (command == clsp_pkg::CMD_SEED)) begin
				gen2_q   <= seed_eff;
				seed_j_q <= J_START;
			end
			if (state_q == clsp_pkg::ST_SEED_STORE) begin
				if (seed_j_q == '0) begin
					gen1_q <= mul1_acc;
					last_q <= mul1_acc;
				end else begin
					seed_j_q <= seed_j_q - 1'b1;
				end
			end

			// draw commit, otherwise release a taken result
			if ((state_q == clsp_pkg::ST_DRAW_DONE) && out_free) begin
				gen1_q      <= mul1_acc;
				gen2_q      <= mul2_acc;
				last_q      <= y_fix;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == clsp_pkg::ST_DRAW_DONE) && out_free) begin
			random_value_q <= y_fix;
		end
	end

	assign res_valid    = res_valid_q;
	assign random_value = random_value_q;

	// check terms
	assign draw_req     = req_accept && (command == clsp_pkg::CMD_DRAW);
	assign res_in_range = (random_value != '0) && (random_value < clsp_pkg::MOD1);

	// checks
	`CLSP_ASSERT_IMPLY(a_res_range, clk, arst_n, res_valid, res_in_range)
	`CLSP_ASSERT_NEXT(a_draw_start, clk, arst_n, draw_req, state_q == clsp_pkg::ST_DRAW_MUL)
	`CLSP_ASSERT_IMPLY(a_slot_range, clk, arst_n, state_q == clsp_pkg::ST_DRAW_READ, quot <= SLOT_MAX)
	`CLSP_ASSERT_IMPLY(a_store_bit, clk, arst_n, state_q == clsp_pkg::ST_SEED_STORE, bit_q == '0)

endmodule
